>>> hdl/p2bpp_pkg.sv
// Shared types and constants for the packed two-bit-per-pixel image blob decoder.
`default_nettype none

package p2bpp_pkg;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PALETTE,
		PH_PIXELS
	} phase_t;

	// Main work carried by one queued command.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_DIM,
		OP_PAL,
		OP_PIX
	} op_t;

	// Record kinds on the output.
	localparam logic [1:0] KIND_DIM = 2'd0;
	localparam logic [1:0] KIND_PAL = 2'd1;
	localparam logic [1:0] KIND_PIX = 2'd2;
	localparam logic [1:0] KIND_ERR = 2'd3;

	// Header byte positions.
	localparam logic [2:0] HPOS_WIDTH_HI  = 3'd0;
	localparam logic [2:0] HPOS_WIDTH_LO  = 3'd1;
	localparam logic [2:0] HPOS_HEIGHT_HI = 3'd2;
	localparam logic [2:0] HPOS_HEIGHT_LO = 3'd3;

	// Color byte positions within a palette entry.
	localparam logic [1:0] CPOS_RED   = 2'd0;
	localparam logic [1:0] CPOS_GREEN = 2'd1;

	// Default depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Width of the back-end record step counter (up to four records per byte).
	localparam int STEP_W = 3;

	// One classified input byte, ready to be expanded into records.
	typedef struct packed {
		op_t         op;
		logic        err;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0]  pcount;
		logic [7:0]  entry;
		logic [7:0]  err_entry;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] row;
		logic [13:0] col_byte;
		logic [7:0]  data;
	} cmd_t;

endpackage

`default_nettype wire

>>> hdl/p2bpp_front.sv
// Front end: takes blob bytes, runs the header/palette/pixel parser and queues commands.
`default_nettype none

module p2bpp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              end_of_blob,
	input  wire logic              q_full,
	output logic                   q_push,
	output p2bpp_pkg::cmd_t        q_cmd
);

	p2bpp_pkg::phase_t phase_q, phase_u;
	logic [2:0]  hpos_q, hpos_u;
	logic [15:0] width_q, width_u;
	logic [15:0] height_q, height_u;
	logic [7:0]  ptotal_q, ptotal_u;
	logic [7:0]  pseen_q, pseen_u;
	logic [1:0]  cpos_q, cpos_u;
	logic [7:0]  red_q, red_u;
	logic [7:0]  green_q, green_u;
	logic [13:0] bir_q, bir_u;
	logic [15:0] row_q, row_u;

	logic [13:0] per_row;
	logic [14:0] bir_inc;
	logic [7:0]  pseen_inc;
	logic        accept;
	p2bpp_pkg::op_t op;

	assign byte_ready = !q_full;
	assign accept     = byte_valid && byte_ready;
	assign per_row    = width_q[15:2];
	assign bir_inc    = {1'b0, bir_q} + 15'd1;
	assign pseen_inc  = pseen_q + 8'd1;

	// Parser step: state after this byte, and the main work it causes.
	always_comb begin
		phase_u  = phase_q;
		hpos_u   = hpos_q;
		width_u  = width_q;
		height_u = height_q;
		ptotal_u = ptotal_q;
		pseen_u  = pseen_q;
		cpos_u   = cpos_q;
		red_u    = red_q;
		green_u  = green_q;
		bir_u    = bir_q;
		row_u    = row_q;
		op       = p2bpp_pkg::OP_NONE;
		unique case (phase_q)
			p2bpp_pkg::PH_HEADER: begin
				unique case (hpos_q)
					p2bpp_pkg::HPOS_WIDTH_HI:  width_u  = {data_byte, 8'h00};
					p2bpp_pkg::HPOS_WIDTH_LO:  width_u  = {width_q[15:8], data_byte};
					p2bpp_pkg::HPOS_HEIGHT_HI: height_u = {data_byte, 8'h00};
					p2bpp_pkg::HPOS_HEIGHT_LO: height_u = {height_q[15:8], data_byte};
					default: begin
						ptotal_u = data_byte;
						op       = p2bpp_pkg::OP_DIM;
						phase_u  = (data_byte == 8'd0) ? p2bpp_pkg::PH_PIXELS
							: p2bpp_pkg::PH_PALETTE;
					end
				endcase
				hpos_u = hpos_q + 3'd1;
			end
			p2bpp_pkg::PH_PALETTE: begin
				unique case (cpos_q)
					p2bpp_pkg::CPOS_RED: begin
						red_u  = data_byte;
						cpos_u = p2bpp_pkg::CPOS_GREEN;
					end
					p2bpp_pkg::CPOS_GREEN: begin
						green_u = data_byte;
						cpos_u  = cpos_q + 2'd1;
					end
					default: begin
						op      = p2bpp_pkg::OP_PAL;
						cpos_u  = p2bpp_pkg::CPOS_RED;
						pseen_u = pseen_inc;
						if (pseen_inc >= ptotal_q) begin
							phase_u = p2bpp_pkg::PH_PIXELS;
						end
					end
				endcase
			end
			p2bpp_pkg::PH_PIXELS: begin
				// Only palettes of three or four colors with at least one byte per row unpack.
				if ((ptotal_q == 8'd3 || ptotal_q == 8'd4) && per_row != 14'd0) begin
					op = p2bpp_pkg::OP_PIX;
					if (bir_inc >= {1'b0, per_row}) begin
						bir_u = 14'd0;
						if (row_q != 16'hFFFF) begin
							row_u = row_q + 16'd1;
						end
					end else begin
						bir_u = bir_inc[13:0];
					end
				end
			end
			default: begin
				phase_u = phase_q;
			end
		endcase
	end

	// Command for the back end, built from this byte and the parser values before and after it.
	always_comb begin
		q_cmd           = '0;
		q_cmd.op        = op;
		q_cmd.err       = end_of_blob && (phase_u != p2bpp_pkg::PH_PIXELS);
		q_cmd.width     = width_u;
		q_cmd.height    = height_u;
		q_cmd.pcount    = ptotal_u;
		q_cmd.entry     = pseen_q;
		q_cmd.err_entry = pseen_u;
		q_cmd.red       = red_q;
		q_cmd.green     = green_q;
		q_cmd.blue      = data_byte;
		q_cmd.row       = row_q;
		q_cmd.col_byte  = bir_q;
		q_cmd.data      = data_byte;
	end

	// A byte that causes no record queues nothing.
	assign q_push = accept && (op != p2bpp_pkg::OP_NONE || q_cmd.err);

	// Parser state; the end of a blob returns everything to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= p2bpp_pkg::PH_HEADER;
			hpos_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			ptotal_q <= '0;
			pseen_q  <= '0;
			cpos_q   <= '0;
			red_q    <= '0;
			green_q  <= '0;
			bir_q    <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if (end_of_blob) begin
				phase_q  <= p2bpp_pkg::PH_HEADER;
				hpos_q   <= '0;
				width_q  <= '0;
				height_q <= '0;
				ptotal_q <= '0;
				pseen_q  <= '0;
				cpos_q   <= '0;
				red_q    <= '0;
				green_q  <= '0;
				bir_q    <= '0;
				row_q    <= '0;
			end else begin
				phase_q  <= phase_u;
				hpos_q   <= hpos_u;
				width_q  <= width_u;
				height_q <= height_u;
				ptotal_q <= ptotal_u;
				pseen_q  <= pseen_u;
				cpos_q   <= cpos_u;
				red_q    <= red_u;
				green_q  <= green_u;
				bir_q    <= bir_u;
				row_q    <= row_u;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/p2bpp_queue.sv
// Short command queue that decouples the parser from the record sequencer.
`default_nettype none

module p2bpp_queue #(
	parameter int DEPTH = p2bpp_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire p2bpp_pkg::cmd_t push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 head_valid,
	output p2bpp_pkg::cmd_t      head_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	p2bpp_pkg::cmd_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/p2bpp_back.sv
// Back end: expands each queued command into result records, one per cycle while the output is not stalled.
`default_nettype none

module p2bpp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire p2bpp_pkg::cmd_t   head_cmd,
	output logic                   pop,
	output logic                   record_valid,
	input  wire logic              record_ready,
	output logic [1:0]             record_kind,
	output logic [15:0]            image_width,
	output logic [15:0]            image_height,
	output logic [7:0]             palette_count,
	output logic [7:0]             entry_index,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic [15:0]            pixel_row,
	output logic [15:0]            pixel_column,
	output logic [1:0]             pixel_value,
	output logic                   last_of_run
);

	logic [p2bpp_pkg::STEP_W-1:0] step_q;
	logic [p2bpp_pkg::STEP_W-1:0] n_main;
	logic [p2bpp_pkg::STEP_W-1:0] total;
	logic                         is_last;
	logic                         load;
	logic                         valid_q;

	logic [1:0]  kind_c;
	logic [7:0]  entry_c, red_c, green_c, blue_c;
	logic [15:0] row_c, col_c;
	logic [1:0]  val_c;

	logic [1:0]  kind_q;
	logic [15:0] width_q, height_q;
	logic [7:0]  pcount_q, entry_q, red_q, green_q, blue_q;
	logic [15:0] row_q, col_q;
	logic [1:0]  val_q;
	logic        last_q;

	// Number of records the command yields before the optional error record.
	always_comb begin
		unique case (head_cmd.op) inside
			p2bpp_pkg::OP_DIM, p2bpp_pkg::OP_PAL: n_main = 3'd1;
			p2bpp_pkg::OP_PIX:                    n_main = 3'd4;
			default:                              n_main = 3'd0;
		endcase
	end

	assign total   = n_main + {2'b00, head_cmd.err};
	assign is_last = (step_q == total - 3'd1);
	assign load    = head_valid && (!valid_q || record_ready);
	assign pop     = load && is_last;

	// Record for the current step of the head command.
	always_comb begin
		kind_c  = p2bpp_pkg::KIND_ERR;
		entry_c = 8'd0;
		red_c   = 8'd0;
		green_c = 8'd0;
		blue_c  = 8'd0;
		row_c   = 16'd0;
		col_c   = 16'd0;
		val_c   = 2'd0;
		if (step_q < n_main) begin
			unique case (head_cmd.op)
				p2bpp_pkg::OP_DIM: begin
					kind_c = p2bpp_pkg::KIND_DIM;
				end
				p2bpp_pkg::OP_PAL: begin
					kind_c  = p2bpp_pkg::KIND_PAL;
					entry_c = head_cmd.entry;
					red_c   = head_cmd.red;
					green_c = head_cmd.green;
					blue_c  = head_cmd.blue;
				end
				p2bpp_pkg::OP_PIX: begin
					kind_c = p2bpp_pkg::KIND_PIX;
					row_c  = head_cmd.row;
					col_c  = {head_cmd.col_byte, step_q[1:0]};
					case (step_q[1:0])
						2'd0:    val_c = head_cmd.data[7:6];
						2'd1:    val_c = head_cmd.data[5:4];
						2'd2:    val_c = head_cmd.data[3:2];
						default: val_c = head_cmd.data[1:0];
					endcase
				end
				default: begin
					kind_c = p2bpp_pkg::KIND_ERR;
				end
			endcase
		end else begin
			// Truncated blob record reports the entries completed so far.
			entry_c = head_cmd.err_entry;
		end
	end

	// Step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= is_last ? '0 : step_q + 3'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (record_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= kind_c;
			width_q  <= head_cmd.width;
			height_q <= head_cmd.height;
			pcount_q <= head_cmd.pcount;
			entry_q  <= entry_c;
			red_q    <= red_c;
			green_q  <= green_c;
			blue_q   <= blue_c;
			row_q    <= row_c;
			col_q    <= col_c;
			val_q    <= val_c;
			last_q   <= is_last;
		end
	end

	assign record_valid  = valid_q;
	assign record_kind   = kind_q;
	assign image_width   = width_q;
	assign image_height  = height_q;
	assign palette_count = pcount_q;
	assign entry_index   = entry_q;
	assign red           = red_q;
	assign green         = green_q;
	assign blue          = blue_q;
	assign pixel_row     = row_q;
	assign pixel_column  = col_q;
	assign pixel_value   = val_q;
	assign last_of_run   = last_q;

`ifndef SYNTHESIS
	// The step counter never runs past the records of the head command.
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> step_q < total)
		else $error("record step beyond command length");

	// The step counter rests at zero between commands.
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> step_q == '0)
		else $error("record step not zero with empty queue");

	// Every queued command yields at least one record.
	a_cmd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && head_cmd.op == p2bpp_pkg::OP_NONE |-> head_cmd.err)
		else $error("queued command yields no record");

	// A stalled output freezes the sequencer.
	a_stall_holds_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !record_ready |=> $stable(step_q))
		else $error("sequencer advanced during output stall");
`endif

endmodule

`default_nettype wire

>>> hdl/packed_2bpp_image_blob_decoder.sv
// Top level of the packed two-bit-per-pixel image blob decoder.
`default_nettype none

// Takes an image blob one byte per request and returns its records: one dimension
// record after the five header bytes, one palette record per three color bytes, and,
// for a palette of three or four entries and a width of at least four, four pixel
// records per later byte; a blob that ends inside the header or palette adds a
// truncated blob record. The parser takes a byte whenever the queue is not full and
// queues at most one command into a short queue (QUEUE_DEPTH entries); the record
// sequencer then sends one record per cycle while the output is not stalled, so a
// pixel byte yields four records and a header or palette byte zero to two, and the
// parser can take new bytes while earlier commands still wait. No clearing pass is
// needed after reset.
module packed_2bpp_image_blob_decoder #(
	parameter int QUEUE_DEPTH = p2bpp_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_blob,
	output logic             record_valid,
	input  wire logic        record_ready,
	output logic [1:0]       record_kind,
	output logic [15:0]      image_width,
	output logic [15:0]      image_height,
	output logic [7:0]       palette_count,
	output logic [7:0]       entry_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [15:0]      pixel_row,
	output logic [15:0]      pixel_column,
	output logic [1:0]       pixel_value,
	output logic             last_of_run
);

	p2bpp_pkg::cmd_t push_cmd;
	p2bpp_pkg::cmd_t head_cmd;
	logic            push;
	logic            full;
	logic            pop;
	logic            head_valid;

	// Parser.
	p2bpp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.data_byte   (data_byte),
		.end_of_blob (end_of_blob),
		.q_full      (full),
		.q_push      (push),
		.q_cmd       (push_cmd)
	);

	// Command queue.
	p2bpp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Record sequencer and output register.
	p2bpp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.record_valid  (record_valid),
		.record_ready  (record_ready),
		.record_kind   (record_kind),
		.image_width   (image_width),
		.image_height  (image_height),
		.palette_count (palette_count),
		.entry_index   (entry_index),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.pixel_row     (pixel_row),
		.pixel_column  (pixel_column),
		.pixel_value   (pixel_value),
		.last_of_run   (last_of_run)
	);

endmodule

`default_nettype wire

>>> bench/tb_packed_2bpp_image_blob_decoder.sv
// Self-checking testbench for the packed two-bit-per-pixel image blob decoder.
module tb_packed_2bpp_image_blob_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	// Third color byte of a palette entry.
	localparam logic [1:0] CPOS_BLUE = 2'd2;

	// One byte request as queued for the driver.
	typedef struct {
		logic [7:0] data;
		logic       last;
	} blob_byte_t;

	// One decoded record, as the block should present it.
	typedef struct {
		logic [1:0]  kind;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0]  pcount;
		logic [7:0]  entry;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] row;
		logic [15:0] col;
		logic [1:0]  value;
		logic        last;
	} record_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_blob = 1'b0;
	logic        record_valid;
	logic        record_ready = 1'b0;
	logic [1:0]  record_kind;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [7:0]  palette_count;
	logic [7:0]  entry_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [15:0] pixel_row;
	logic [15:0] pixel_column;
	logic [1:0]  pixel_value;
	logic        last_of_run;

	blob_byte_t  blob_bytes[$];
	record_t     pending_records[$];
	int unsigned send_idle_pct = 21;
	int unsigned recv_idle_pct = 59;
	int unsigned queued_bytes = 0;
	int          mismatches = 0;

	// Shadow copy of the parser state.
	p2bpp_pkg::phase_t phase;
	logic [2:0]  hdr_pos;
	logic [15:0] w_hold;
	logic [15:0] h_hold;
	logic [7:0]  pal_total;
	logic [7:0]  pal_seen;
	logic [1:0]  color_pos;
	logic [7:0]  red_hold;
	logic [7:0]  green_hold;
	logic [13:0] col_byte;
	logic [15:0] row_count;

	packed_2bpp_image_blob_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.data_byte    (data_byte),
		.end_of_blob  (end_of_blob),
		.record_valid (record_valid),
		.record_ready (record_ready),
		.record_kind  (record_kind),
		.image_width  (image_width),
		.image_height (image_height),
		.palette_count(palette_count),
		.entry_index  (entry_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.pixel_row    (pixel_row),
		.pixel_column (pixel_column),
		.pixel_value  (pixel_value),
		.last_of_run  (last_of_run)
	);

	always #10 clk = ~clk;

	// Return the shadow parser to its idle state, as after reset or a blob end.
	function automatic void clear_decoder_state();
		phase = p2bpp_pkg::PH_HEADER;
		hdr_pos = 3'd0;
		w_hold = 16'd0;
		h_hold = 16'd0;
		pal_total = 8'd0;
		pal_seen = 8'd0;
		color_pos = p2bpp_pkg::CPOS_RED;
		red_hold = 8'd0;
		green_hold = 8'd0;
		col_byte = 14'd0;
		row_count = 16'd0;
	endfunction

	// Build a record; the header fields always come from the held values.
	function automatic record_t make_record(input logic [1:0] kind, input logic [7:0] entry,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [15:0] row, input logic [15:0] col, input logic [1:0] value);
		record_t rec;
		rec.kind = kind;
		rec.width = w_hold;
		rec.height = h_hold;
		rec.pcount = pal_total;
		rec.entry = entry;
		rec.red = r;
		rec.green = g;
		rec.blue = b;
		rec.row = row;
		rec.col = col;
		rec.value = value;
		rec.last = 1'b0;
		return rec;
	endfunction

	// Advance the shadow parser by one byte and queue the records it yields.
	function automatic void decode_byte(input logic [7:0] d, input logic eob);
		record_t     recs[$];
		logic [13:0] per_row;
		int          k;
		per_row = w_hold[15:2];
		case (phase)
		p2bpp_pkg::PH_HEADER: begin
			case (hdr_pos)
			p2bpp_pkg::HPOS_WIDTH_HI: w_hold = {d, 8'h00};
			p2bpp_pkg::HPOS_WIDTH_LO: w_hold[7:0] = d;
			p2bpp_pkg::HPOS_HEIGHT_HI: h_hold = {d, 8'h00};
			p2bpp_pkg::HPOS_HEIGHT_LO: h_hold[7:0] = d;
			default: begin
				pal_total = d;
				recs = {recs, make_record(p2bpp_pkg::KIND_DIM, 8'd0, 8'd0, 8'd0, 8'd0,
					16'd0, 16'd0, 2'd0)};
				phase = (d == 8'd0) ? p2bpp_pkg::PH_PIXELS : p2bpp_pkg::PH_PALETTE;
			end
			endcase
			hdr_pos = hdr_pos + 3'd1;
		end
		p2bpp_pkg::PH_PALETTE: begin
			case (color_pos)
			p2bpp_pkg::CPOS_RED: begin
				red_hold = d;
				color_pos = p2bpp_pkg::CPOS_GREEN;
			end
			p2bpp_pkg::CPOS_GREEN: begin
				green_hold = d;
				color_pos = CPOS_BLUE;
			end
			default: begin
				recs = {recs, make_record(p2bpp_pkg::KIND_PAL, pal_seen, red_hold,
					green_hold, d, 16'd0, 16'd0, 2'd0)};
				color_pos = p2bpp_pkg::CPOS_RED;
				pal_seen = pal_seen + 8'd1;
				if (pal_seen >= pal_total)
					phase = p2bpp_pkg::PH_PIXELS;
			end
			endcase
		end
		default: begin
			// Only a 2-bit palette with at least one byte per row produces pixels.
			if ((pal_total == 8'd3 || pal_total == 8'd4) && per_row != 14'd0) begin
				for (k = 0; k < 4; k++)
					recs = {recs, make_record(p2bpp_pkg::KIND_PIX, 8'd0, 8'd0, 8'd0, 8'd0,
						row_count, {col_byte, 2'b00} + 16'(k), 2'(d >> (6 - 2 * k)))};
				col_byte = col_byte + 14'd1;
				if (col_byte >= per_row) begin
					col_byte = 14'd0;
					if (row_count != 16'hFFFF)
						row_count = row_count + 16'd1;
				end
			end
		end
		endcase
		// A blob that stops before the pixel section is reported as truncated.
		if (eob) begin
			if (phase != p2bpp_pkg::PH_PIXELS)
				recs = {recs, make_record(p2bpp_pkg::KIND_ERR, pal_seen, 8'd0, 8'd0, 8'd0,
					16'd0, 16'd0, 2'd0)};
			clear_decoder_state();
		end
		if (recs.size() != 0)
			recs[recs.size() - 1].last = 1'b1;
		pending_records = {pending_records, recs};
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Byte driver: presents queued requests, idling at random between them.
	always @(posedge clk or negedge arst_n) begin : byte_driver
		blob_byte_t nxt;
		if (!arst_n) begin
			byte_valid <= 1'b0;
			data_byte <= 8'h00;
			end_of_blob <= 1'b0;
		end else begin
			if (byte_valid && byte_ready)
				decode_byte(data_byte, end_of_blob);
			if (!byte_valid || byte_ready) begin
				if (blob_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = blob_bytes.pop_front();
					byte_valid <= 1'b1;
					data_byte <= nxt.data;
					end_of_blob <= nxt.last;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Record monitor: stalls at random and checks each accepted record in order.
	always @(posedge clk or negedge arst_n) begin : record_monitor
		record_t want;
		if (!arst_n) begin
			record_ready <= 1'b0;
		end else begin
			if (record_valid && record_ready) begin
				if (pending_records.size() == 0) begin
					$error("unexpected record of kind %0d", record_kind);
					mismatches++;
				end else begin
					want = pending_records.pop_front();
					check_field("record_kind", want.kind, record_kind);
					check_field("image_width", want.width, image_width);
					check_field("image_height", want.height, image_height);
					check_field("palette_count", want.pcount, palette_count);
					check_field("entry_index", want.entry, entry_index);
					check_field("red", want.red, red);
					check_field("green", want.green, green);
					check_field("blue", want.blue, blue);
					check_field("pixel_row", want.row, pixel_row);
					check_field("pixel_column", want.col, pixel_column);
					check_field("pixel_value", want.value, pixel_value);
					check_field("last_of_run", want.last, last_of_run);
				end
			end
			record_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_bytes(input logic [7:0] bytes[$]);
		blob_byte_t b;
		foreach (bytes[i]) begin
			b.data = bytes[i];
			b.last = (i == bytes.size() - 1);
			blob_bytes = {blob_bytes, b};
		end
		queued_bytes += bytes.size();
	endtask

	// Complete blob: header, full palette of random colors, random pixel bytes.
	task automatic add_full_blob(input logic [15:0] w, input logic [7:0] cnt,
			input int unsigned npix);
		logic [7:0]  bytes[$];
		logic [15:0] h;
		h = 16'($urandom);
		bytes = '{w[15:8], w[7:0], h[15:8], h[7:0], cnt};
		repeat (3 * cnt + npix)
			bytes = {bytes, 8'($urandom)};
		push_bytes(bytes);
	endtask

	// Mostly well-formed blobs with random content, some cut short on purpose.
	task automatic add_random_blob();
		logic [7:0]  bytes[$];
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0]  cnt;
		int unsigned sel;
		int unsigned ending;
		int unsigned keep;
		sel = $urandom_range(9);
		if (sel == 0)
			w = 16'($urandom_range(3));
		else if (sel == 1)
			w = 16'hFFFF;
		else if (sel == 2)
			w = 16'($urandom);
		else
			w = 16'($urandom_range(4, 40));
		h = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4));
		sel = $urandom_range(9);
		if (sel <= 5)
			cnt = 8'($urandom_range(3, 4));
		else if (sel == 6)
			cnt = 8'd0;
		else if (sel == 7)
			cnt = 8'($urandom_range(1, 2));
		else if (sel == 8)
			cnt = 8'($urandom_range(5, 8));
		else
			cnt = 8'($urandom_range(9, 255));
		ending = $urandom_range(9);
		if (cnt > 8'd8 && ending > 0)
			ending = 1;
		bytes = '{w[15:8], w[7:0], h[15:8], h[7:0], cnt};
		repeat (3 * cnt)
			bytes = {bytes, 8'($urandom)};
		if (ending == 0) begin
			// Cut inside the header, possibly on the count byte itself.
			keep = $urandom_range(1, 5);
		end else if (ending <= 2 && cnt != 8'd0) begin
			// Cut inside the palette.
			keep = 5 + $urandom_range(0, (3 * cnt - 1 < 20) ? 3 * cnt - 1 : 20);
		end else begin
			keep = bytes.size();
			repeat ($urandom_range(0, 10))
				bytes = {bytes, 8'($urandom)};
		end
		if (keep < bytes.size())
			bytes = bytes[0:keep - 1];
		push_bytes(bytes);
	endtask

	// Stray bytes, which also land in the middle of whatever state is current.
	task automatic add_noise();
		blob_byte_t b;
		repeat ($urandom_range(1, 6)) begin
			b.data = 8'($urandom);
			b.last = ($urandom_range(3) == 0);
			blob_bytes = {blob_bytes, b};
			queued_bytes++;
		end
	endtask

	task automatic add_random_items(input int unsigned count);
		int unsigned target;
		target = queued_bytes + count;
		while (queued_bytes < target) begin
			if ($urandom_range(9) == 0)
				add_noise();
			else
				add_random_blob();
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (blob_bytes.size() != 0 || byte_valid || pending_records.size() != 0);
	endtask

	// Stimulus sequence and final verdict.
	initial begin
		clear_decoder_state();
		// Width 8, height 2, three colors, two of them at both extremes, then a partial second row.
		push_bytes('{8'h00, 8'h08, 8'h00, 8'h02, 8'h03,
			8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56,
			8'hE4, 8'h1B, 8'hFF});
		// Blob that stops inside the header.
		push_bytes('{8'hFF, 8'hFF});
		// Empty palette: the pixel byte yields nothing.
		push_bytes('{8'h00, 8'h03, 8'hFF, 8'hFF, 8'h00, 8'hAA});
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		// Hold the next requests back until every record has come out.
		wait_drained();
		add_random_items(110);
		wait_drained();
		send_idle_pct = 59;
		recv_idle_pct = 21;
		add_random_items(110);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random_items(100);
		// Narrowest unpacking width: every pixel byte closes a row.
		add_full_blob(16'd4, 8'd4, 8);
		wait_drained();
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#60_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
